@@ sv/cls_pkg.sv @@
// cls_pkg: shared constants, codes and character classes for the c line identifier scanner
// no dependencies; imported by the interfaces and the top level
package cls_pkg;

	localparam int MaxTargetChars = 8;

	localparam int CharW = 8;
	localparam int WordW = 64;
	localparam int LenW = 4;
	localparam int ModeW = 4;
	localparam int ErrW = 2;
	localparam int AddrW = 4;
	localparam int DataW = 64;

	// lexer modes
	localparam logic [ModeW-1:0] MODE_NORMAL     = 4'd0;
	localparam logic [ModeW-1:0] MODE_IDENT      = 4'd1;
	localparam logic [ModeW-1:0] MODE_SLASH      = 4'd2;
	localparam logic [ModeW-1:0] MODE_LINECMT    = 4'd3;
	localparam logic [ModeW-1:0] MODE_BLOCK      = 4'd4;
	localparam logic [ModeW-1:0] MODE_BLOCK_STAR = 4'd5;
	localparam logic [ModeW-1:0] MODE_STR        = 4'd6;
	localparam logic [ModeW-1:0] MODE_STR_ESC    = 4'd7;
	localparam logic [ModeW-1:0] MODE_CHR        = 4'd8;
	localparam logic [ModeW-1:0] MODE_CHR_ESC    = 4'd9;

	// line end error codes
	localparam logic [ErrW-1:0] ERR_OK    = 2'd0;
	localparam logic [ErrW-1:0] ERR_STR   = 2'd1;
	localparam logic [ErrW-1:0] ERR_CHR   = 2'd2;
	localparam logic [ErrW-1:0] ERR_BLOCK = 2'd3;

	// register indexes, decoded from paddr[3]
	localparam logic REG_TARGET_WORD   = 1'b0;
	localparam logic REG_TARGET_LENGTH = 1'b1;

	localparam logic [CharW-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [CharW-1:0] CH_SLASH      = 8'h2F;
	localparam logic [CharW-1:0] CH_STAR       = 8'h2A;
	localparam logic [CharW-1:0] CH_DQUOTE     = 8'h22;
	localparam logic [CharW-1:0] CH_SQUOTE     = 8'h27;
	localparam logic [CharW-1:0] CH_BACKSLASH  = 8'h5C;

	typedef struct packed {
		logic             ident_start;
		logic             ident_match_end;
		logic [ErrW-1:0]  error_code;
		logic             line_uses;
		logic             line_done;
	} result_t;

	function automatic logic is_head(input logic [CharW-1:0] c);
		logic r;
		r = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDERSCORE);
		return r;
	endfunction

	function automatic logic is_tail(input logic [CharW-1:0] c);
		logic r;
		r = is_head(c) || (c >= 8'h30 && c <= 8'h39);
		return r;
	endfunction

endpackage

@@ sv/cls_ifs.sv @@
// cls_ifs: valid/ready stream interfaces for character items and scan result items
// depends on cls_pkg for field widths
interface cls_char_if import cls_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] char_code;
	logic             last_in_line;

	modport source (output valid, output char_code, output last_in_line, input ready);
	modport sink (input valid, input char_code, input last_in_line, output ready);
endinterface

interface cls_result_if import cls_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            ident_start;
	logic            ident_match_end;
	logic [ErrW-1:0] error_code;
	logic            line_uses;
	logic            line_done;

	modport source (output valid, output ident_start, output ident_match_end,
		output error_code, output line_uses, output line_done, input ready);
	modport sink (input valid, input ident_start, input ident_match_end,
		input error_code, input line_uses, input line_done, output ready);
endinterface

@@ sv/c_line_identifier_scanner.sv @@
// c_line_identifier_scanner: top level, lexer state, apb registers and result register
// depends on cls_pkg and the stream interfaces in cls_ifs.sv
//
// Takes one C source byte per item and returns one result item per byte, one item
// per clock cycle sustained while results.ready stays high. A byte passes an input
// register, then the lexer state update and identifier compare into the result
// register; the single lexer state update per cycle sets the rate. While a result
// waits in the result register, an empty input register still takes a new byte.
// Registers: target_word at byte address 0, target_length at 8 (64-bit apb data);
// write them only while the scanner is idle.
module c_line_identifier_scanner import cls_pkg::*; #(
	parameter int MAX_TARGET_CHARS = MaxTargetChars
) (
	input  logic              clk,
	input  logic              arst_n,
	cls_char_if.sink          chars,
	cls_result_if.source      results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AddrW-1:0]  paddr,
	input  logic [DataW-1:0]  pwdata,
	output logic [DataW-1:0]  prdata,
	output logic              pready
);

	logic [WordW-1:0] target_word_q;
	logic [LenW-1:0]  target_length_q;

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;

	logic [ModeW-1:0] mode_q, mode_n;
	logic [LenW-1:0]  len_q, len_n;
	logic             match_q, match_n;
	logic             seen_q, seen_n;

	logic             out_valid_q;
	result_t          res_q, res_n;

	logic             advance;
	logic             normal_scan;
	logic             target_ok;
	logic [CharW-1:0] tbyte;
	logic             cfg_wr;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_word_q   <= '0;
			target_length_q <= LenW'(1);
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_TARGET_WORD:   target_word_q <= pwdata;
				REG_TARGET_LENGTH: target_length_q <= pwdata[LenW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_TARGET_WORD:   prdata = target_word_q;
			REG_TARGET_LENGTH: prdata = {{(DataW-LenW){1'b0}}, target_length_q};
			default:           prdata = '0;
		endcase
	end

	// handshakes
	assign advance       = valid_s1 && (!out_valid_q || results.ready);
	assign chars.ready   = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_in_line;
		end
	end

	// lexer step
	assign target_ok = (target_length_q != '0) && (target_length_q <= LenW'(MAX_TARGET_CHARS));
	assign tbyte     = target_word_q[{len_q[2:0], 3'b000} +: CharW];

	always_comb begin
		mode_n      = mode_q;
		len_n       = len_q;
		match_n     = match_q;
		seen_n      = seen_q;
		normal_scan = 1'b0;
		res_n       = '0;

		case (mode_q)
			MODE_IDENT: begin
				if (is_tail(char_s1)) begin
					if (match_q)
						match_n = (len_q < target_length_q) && (len_q < LenW'(MAX_TARGET_CHARS))
							&& (char_s1 == tbyte);
					if (len_q != {LenW{1'b1}})
						len_n = len_q + LenW'(1);
				end else begin
					res_n.ident_match_end = match_q && (len_q == target_length_q);
					normal_scan = 1'b1;
				end
			end
			MODE_SLASH: begin
				if (char_s1 == CH_SLASH)
					mode_n = MODE_LINECMT;
				else if (char_s1 == CH_STAR)
					mode_n = MODE_BLOCK;
				else
					normal_scan = 1'b1;
			end
			MODE_LINECMT: ;
			MODE_BLOCK: begin
				if (char_s1 == CH_STAR)
					mode_n = MODE_BLOCK_STAR;
			end
			MODE_BLOCK_STAR: begin
				if (char_s1 == CH_SLASH)
					mode_n = MODE_NORMAL;
				else if (char_s1 != CH_STAR)
					mode_n = MODE_BLOCK;
			end
			MODE_STR: begin
				if (char_s1 == CH_BACKSLASH)
					mode_n = MODE_STR_ESC;
				else if (char_s1 == CH_DQUOTE)
					mode_n = MODE_NORMAL;
			end
			MODE_STR_ESC: mode_n = MODE_STR;
			MODE_CHR: begin
				if (char_s1 == CH_BACKSLASH)
					mode_n = MODE_CHR_ESC;
				else if (char_s1 == CH_SQUOTE)
					mode_n = MODE_NORMAL;
			end
			MODE_CHR_ESC: mode_n = MODE_CHR;
			default: normal_scan = 1'b1;
		endcase

		if (normal_scan) begin
			mode_n = MODE_NORMAL;
			if (is_head(char_s1)) begin
				mode_n            = MODE_IDENT;
				len_n             = LenW'(1);
				match_n           = target_ok && (char_s1 == target_word_q[CharW-1:0]);
				res_n.ident_start = 1'b1;
			end else if (char_s1 == CH_DQUOTE) begin
				mode_n = MODE_STR;
			end else if (char_s1 == CH_SQUOTE) begin
				mode_n = MODE_CHR;
			end else if (char_s1 == CH_SLASH) begin
				mode_n = MODE_SLASH;
			end
		end

		// an identifier running into the line end still counts
		if (last_s1 && mode_n == MODE_IDENT && match_n && len_n == target_length_q)
			res_n.ident_match_end = 1'b1;
		if (res_n.ident_match_end)
			seen_n = 1'b1;

		res_n.line_done = last_s1;
		if (last_s1) begin
			if (mode_n == MODE_STR || mode_n == MODE_STR_ESC)
				res_n.error_code = ERR_STR;
			else if (mode_n == MODE_CHR || mode_n == MODE_CHR_ESC)
				res_n.error_code = ERR_CHR;
			else if (mode_n == MODE_BLOCK || mode_n == MODE_BLOCK_STAR)
				res_n.error_code = ERR_BLOCK;
			else
				res_n.error_code = ERR_OK;
			res_n.line_uses = seen_n && (res_n.error_code == ERR_OK);
			mode_n  = MODE_NORMAL;
			len_n   = '0;
			match_n = 1'b0;
			seen_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			len_q   <= '0;
			match_q <= 1'b0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_n;
			len_q   <= len_n;
			match_q <= match_n;
			seen_q  <= seen_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || results.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_n;
	end

	assign results.valid           = out_valid_q;
	assign results.ident_start     = res_q.ident_start;
	assign results.ident_match_end = res_q.ident_match_end;
	assign results.error_code      = res_q.error_code;
	assign results.line_uses       = res_q.line_uses;
	assign results.line_done       = res_q.line_done;

endmodule
